/* src/cpd_pkg.sv */
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types, constants and the byte-wide CRC-32 step for the deframer.
// ----------------------------------------------------------------------------
package cpd_pkg;

  localparam int unsigned HDR_LEN     = 8;     // header bytes
  localparam int unsigned HDR_CRC_END = 12;    // header plus its crc
  localparam int unsigned CRC_LEN     = 4;
  localparam int unsigned MAX_PAYLOAD = 512;
  localparam int unsigned LEN_SAT     = 1023;  // reported length ceiling
  localparam int unsigned POS_W       = 10;
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned PTR_W       = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W       = PTR_W + 1;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_TYPE  = 3'd1,
    ST_LEN_BIG   = 3'd2,
    ST_TRUNC_PAY = 3'd3,
    ST_HDR_CRC   = 3'd4,
    ST_PAY_CRC   = 3'd5,
    ST_SHORT     = 3'd6
  } status_e;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e        kind;
    logic [7:0]   payload_byte;
    status_e      status;
    logic [1:0]   packet_type;
    logic         truncated_flag;
    logic [4:0]   window;
    logic [7:0]   sequence_number;
    logic [9:0]   payload_length;
    logic [31:0]  timestamp;
    logic         last;
  } res_t;

  // up to two results per accepted byte
  typedef struct packed {
    logic [1:0] n;
    res_t       first;
    res_t       second;
  } push_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ (CRC_POLY & {32{r[0]}});
    end
    return r;
  endfunction

endpackage

/* src/cpd_frame_ctrl.sv */
// ----------------------------------------------------------------------------
// cpd_frame_ctrl
// Frame state: header capture, crc checks, payload forwarding, status build.
// ----------------------------------------------------------------------------
module cpd_frame_ctrl import cpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_frame_i,
  output push_t       push_o
);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       hdr_q [HDR_LEN];
  logic [7:0]       hdr_d [HDR_LEN];
  logic [31:0]      crc_q, crc_d;
  logic [31:0]      rcrc_q, rcrc_d;
  status_e          err_q, err_d;
  logic             hp_q, hp_d;

  logic [15:0]      len_cur, len_new, len_rep;
  logic [16:0]      pos_ext, pos_next_ext, pay_end, crc_end;
  logic             fwd;
  status_e          st;
  res_t             pay_res, st_res;

  always_comb begin
    pos_d   = pos_q;
    hdr_d   = hdr_q;
    crc_d   = crc_q;
    rcrc_d  = rcrc_q;
    err_d   = err_q;
    hp_d    = hp_q;
    fwd     = 1'b0;
    len_cur = {hdr_q[2], hdr_q[3]};
    len_new = {hdr_q[2], data_byte_i};
    pos_ext = {7'd0, pos_q};
    pay_end = 17'(len_cur) + 17'(HDR_CRC_END);
    crc_end = pay_end + 17'(CRC_LEN);

    if (pos_q < POS_W'(HDR_LEN)) begin
      hdr_d[pos_q[2:0]] = data_byte_i;
      crc_d = crc32_byte(crc_q, data_byte_i);
      if (pos_q == '0 && data_byte_i[7:6] == 2'd0 && err_q == ST_OK) begin
        err_d = ST_BAD_TYPE;
      end
      if (pos_q == POS_W'(3) && err_q == ST_OK) begin
        if (len_new > 16'(MAX_PAYLOAD)) begin
          err_d = ST_LEN_BIG;
        end else if (hdr_q[0][5] && len_new != 16'd0) begin
          err_d = ST_TRUNC_PAY;
        end
      end
    end else if (pos_q < POS_W'(HDR_CRC_END)) begin
      rcrc_d = {rcrc_q[23:0], data_byte_i};
      if (pos_q == POS_W'(HDR_CRC_END - 1) && err_q == ST_OK) begin
        if (rcrc_d != ~crc_q) begin
          err_d = ST_HDR_CRC;
        end else begin
          hp_d = 1'b1;
        end
        crc_d  = CRC_INIT;
        rcrc_d = '0;
      end
    end else if (hp_q) begin
      if (pos_ext < pay_end) begin
        fwd   = 1'b1;
        crc_d = crc32_byte(crc_q, data_byte_i);
      end else if (len_cur != 16'd0 && pos_ext < crc_end) begin
        rcrc_d = {rcrc_q[23:0], data_byte_i};
        if (pos_ext == crc_end - 17'd1 && rcrc_d != ~crc_q && err_q == ST_OK) begin
          err_d = ST_PAY_CRC;
        end
      end
    end

    // position saturates on very long frames
    if (pos_q != '1) begin
      pos_d = pos_q + POS_W'(1);
    end
  end

  // status report from the updated state
  always_comb begin
    len_rep      = {hdr_d[2], hdr_d[3]};
    pos_next_ext = {7'd0, pos_d};
    if (err_d != ST_OK) begin
      st = err_d;
    end else if (!hp_d) begin
      st = ST_SHORT;
    end else if (pos_next_ext < 17'(len_rep) + 17'(HDR_CRC_END)
                 + ((len_rep != 16'd0) ? 17'(CRC_LEN) : 17'd0)) begin
      st = ST_SHORT;
    end else begin
      st = ST_OK;
    end

    st_res.kind            = KIND_STATUS;
    st_res.payload_byte    = '0;
    st_res.status          = st;
    st_res.packet_type     = hdr_d[0][7:6];
    st_res.truncated_flag  = hdr_d[0][5];
    st_res.window          = hdr_d[0][4:0];
    st_res.sequence_number = hdr_d[1];
    st_res.payload_length  = (len_rep > 16'(LEN_SAT)) ? 10'(LEN_SAT) : len_rep[9:0];
    st_res.timestamp       = {hdr_d[7], hdr_d[6], hdr_d[5], hdr_d[4]};
    st_res.last            = 1'b1;

    pay_res              = '0;
    pay_res.kind         = KIND_PAYLOAD;
    pay_res.payload_byte = data_byte_i;
    pay_res.status       = ST_OK;
    pay_res.last         = !end_of_frame_i;
  end

  always_comb begin
    push_o = '0;
    if (accept_i) begin
      if (fwd) begin
        push_o.first  = pay_res;
        push_o.second = st_res;
        push_o.n      = end_of_frame_i ? 2'd2 : 2'd1;
      end else if (end_of_frame_i) begin
        push_o.first = st_res;
        push_o.n     = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      hdr_q  <= '{default: '0};
      crc_q  <= CRC_INIT;
      rcrc_q <= '0;
      err_q  <= ST_OK;
      hp_q   <= 1'b0;
    end else if (accept_i) begin
      if (end_of_frame_i) begin
        pos_q  <= '0;
        hdr_q  <= '{default: '0};
        crc_q  <= CRC_INIT;
        rcrc_q <= '0;
        err_q  <= ST_OK;
        hp_q   <= 1'b0;
      end else begin
        pos_q  <= pos_d;
        hdr_q  <= hdr_d;
        crc_q  <= crc_d;
        rcrc_q <= rcrc_d;
        err_q  <= err_d;
        hp_q   <= hp_d;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // a passed header never coexists with a latched header-stage error
  a_pass_no_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hp_q |-> (err_q == ST_OK || err_q == ST_PAY_CRC))
    else $error("header passed with early error latched");

  a_fwd_needs_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.n != 2'd0 && push_o.first.kind == KIND_PAYLOAD) |-> hp_q)
    else $error("payload forwarded without a passed header");

  a_eof_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && end_of_frame_i) |=> (pos_q == '0 && !hp_q && err_q == ST_OK))
    else $error("frame state not cleared after end of frame");
`endif

endmodule

/* src/cpd_out_fifo.sv */
// ----------------------------------------------------------------------------
// cpd_out_fifo
// Small result queue taking up to two results a cycle, draining one unless stalled.
// ----------------------------------------------------------------------------
module cpd_out_fifo import cpd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  full_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  output res_t  head_o
);

  res_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  assign out_valid_o = cnt_q != '0;
  assign head_o      = mem_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;
  // room for two is kept so an end byte with payload always fits
  assign full_o      = cnt_q > CNT_W'(FIFO_DEPTH - 2);

  always_comb begin
    wr_d  = wr_q + PTR_W'(push_i.n);
    rd_d  = rd_q + PTR_W'(pop);
    cnt_d = cnt_q + CNT_W'(push_i.n) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.n == 2'd2) begin
      mem_q[wr_q + PTR_W'(1)] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n != 2'd0) |-> (CNT_W'(push_i.n) + cnt_q <= CNT_W'(FIFO_DEPTH)))
    else $error("result queue overflow");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != CNT_W'(FIFO_DEPTH)) |-> (PTR_W'(wr_q - rd_q) == cnt_q[PTR_W-1:0]))
    else $error("queue pointers and count disagree");

  a_push_two_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n == 2'd2) |-> (push_i.second.kind == KIND_STATUS && push_i.second.last))
    else $error("second result is not a closing status");
`endif

endmodule

/* src/crc32_packet_deframer_top.sv */
// Each result is queued in a four-entry queue when its byte is accepted and
// is presented once the results ahead of it have drained. Throughput: one
// byte per cycle while the input is not stalled; a closing payload byte
// yields two results. Input stalls while more than two results are queued.
// Reset (rst_ni low, asynchronous) empties the queue and clears frame state.
// ----------------------------------------------------------------------------
// crc32_packet_deframer_top
// Byte-stream deframer with crc-32 checked header and payload.
// ----------------------------------------------------------------------------
module crc32_packet_deframer_top import cpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_frame_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [7:0]  payload_byte_o,
  output logic [2:0]  status_o,
  output logic [1:0]  packet_type_o,
  output logic        truncated_flag_o,
  output logic [4:0]  window_o,
  output logic [7:0]  sequence_number_o,
  output logic [9:0]  payload_length_o,
  output logic [31:0] timestamp_o,
  output logic        last_o
);

  logic  accept;
  push_t push;
  res_t  head;

  assign accept = in_valid_i && !in_stall_o;

  cpd_frame_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (data_byte_i),
    .end_of_frame_i (end_of_frame_i),
    .push_o         (push)
  );

  cpd_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign result_kind_o     = head.kind;
  assign payload_byte_o    = head.payload_byte;
  assign status_o          = head.status;
  assign packet_type_o     = head.packet_type;
  assign truncated_flag_o  = head.truncated_flag;
  assign window_o          = head.window;
  assign sequence_number_o = head.sequence_number;
  assign payload_length_o  = head.payload_length;
  assign timestamp_o       = head.timestamp;
  assign last_o            = head.last;

endmodule

/* tb/sv/crc32_packet_deframer_top_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// crc32_packet_deframer_top_test
// Feeds framed byte streams (good frames, header and payload crc faults,
// cut-off and over-long frames, header field errors and noise) into the
// deframer under several sender and receiver idling patterns. Every
// forwarded payload byte and every end-of-frame status report is checked
// against a cycle-free model of the deframer kept inside the bench.
// ----------------------------------------------------------------------------
module crc32_packet_deframer_top_test;
  import cpd_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        end_of_frame;
  logic        out_valid;
  logic        out_stall;
  logic        result_kind;
  logic [7:0]  payload_byte;
  logic [2:0]  status;
  logic [1:0]  packet_type;
  logic        truncated_flag;
  logic [4:0]  window;
  logic [7:0]  sequence_number;
  logic [9:0]  payload_length;
  logic [31:0] timestamp;
  logic        last;

  crc32_packet_deframer_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .data_byte_i       (data_byte),
    .end_of_frame_i    (end_of_frame),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .result_kind_o     (result_kind),
    .payload_byte_o    (payload_byte),
    .status_o          (status),
    .packet_type_o     (packet_type),
    .truncated_flag_o  (truncated_flag),
    .window_o          (window),
    .sequence_number_o (sequence_number),
    .payload_length_o  (payload_length),
    .timestamp_o       (timestamp),
    .last_o            (last)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // deframer model state
  int unsigned byte_pos;
  logic [7:0]  hdr [8];
  logic [31:0] run_crc;
  logic [31:0] rx_crc;
  status_e     latched_err;
  logic        hdr_ok;

  res_t        owed_results [$];
  logic [7:0]  frame_buf [$];
  int unsigned n_bad;
  int unsigned bytes_sent;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  function automatic logic [31:0] crc32_shift(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c;
    for (int k = 0; k < 8; k++) begin
      if (r[0] ^ b[k]) begin
        r = (r >> 1) ^ CRC_POLY;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  function automatic void clear_frame_state();
    byte_pos = 0;
    for (int i = 0; i < 8; i++) hdr[i] = 8'd0;
    run_crc = CRC_INIT;
    rx_crc = 32'd0;
    latched_err = ST_OK;
    hdr_ok = 1'b0;
  endfunction

  function automatic void deframe_byte(input logic [7:0] b, input logic eof);
    int unsigned idx;
    logic [15:0] len;
    res_t        r;
    status_e     st;
    idx = byte_pos;
    if (idx < HDR_LEN) begin
      hdr[idx] = b;
      run_crc = crc32_shift(run_crc, b);
      if (idx == 0 && b[7:6] == 2'd0 && latched_err == ST_OK) latched_err = ST_BAD_TYPE;
      if (idx == 3 && latched_err == ST_OK) begin
        len = {hdr[2], hdr[3]};
        if (len > MAX_PAYLOAD) latched_err = ST_LEN_BIG;
        else if (hdr[0][5] && len != 0) latched_err = ST_TRUNC_PAY;
      end
    end else if (idx < HDR_CRC_END) begin
      rx_crc = {rx_crc[23:0], b};
      if (idx == HDR_CRC_END - 1 && latched_err == ST_OK) begin
        if (rx_crc != ~run_crc) latched_err = ST_HDR_CRC;
        else hdr_ok = 1'b1;
        run_crc = CRC_INIT;
        rx_crc = 32'd0;
      end
    end else if (hdr_ok) begin
      len = {hdr[2], hdr[3]};
      if (idx < HDR_CRC_END + len) begin
        run_crc = crc32_shift(run_crc, b);
        r = '0;
        r.kind = KIND_PAYLOAD;
        r.payload_byte = b;
        r.last = !eof;
        owed_results.push_back(r);
      end else if (len != 0 && idx < HDR_CRC_END + CRC_LEN + len) begin
        rx_crc = {rx_crc[23:0], b};
        if (idx == HDR_CRC_END + CRC_LEN - 1 + len && rx_crc != ~run_crc &&
            latched_err == ST_OK) latched_err = ST_PAY_CRC;
      end
    end
    if (byte_pos != 32'hFFFF_FFFF) byte_pos++;
    if (eof) begin
      len = {hdr[2], hdr[3]};
      if (latched_err != ST_OK) st = latched_err;
      else if (!hdr_ok) st = ST_SHORT;
      else if (byte_pos < HDR_CRC_END + len + ((len != 0) ? CRC_LEN : 0)) st = ST_SHORT;
      else st = ST_OK;
      r = '0;
      r.kind = KIND_STATUS;
      r.status = st;
      r.packet_type = hdr[0][7:6];
      r.truncated_flag = hdr[0][5];
      r.window = hdr[0][4:0];
      r.sequence_number = hdr[1];
      r.payload_length = (len > LEN_SAT) ? 10'(LEN_SAT) : len[9:0];
      r.timestamp = {hdr[7], hdr[6], hdr[5], hdr[4]};
      r.last = 1'b1;
      owed_results.push_back(r);
      clear_frame_state();
    end
  endfunction

  function automatic string fmt_result(input res_t r);
    return $sformatf({"kind=%0d byte=%02h st=%0d type=%0d tr=%0d win=%0d seq=%0d",
                      " len=%0d ts=%08h last=%0d"},
                     r.kind, r.payload_byte, r.status, r.packet_type, r.truncated_flag,
                     r.window, r.sequence_number, r.payload_length, r.timestamp, r.last);
  endfunction

  always @(posedge clk_i) begin : result_check
    res_t want;
    res_t got;
    if (rst_ni && out_valid && !out_stall) begin
      got.kind = kind_e'(result_kind);
      got.payload_byte = payload_byte;
      got.status = status_e'(status);
      got.packet_type = packet_type;
      got.truncated_flag = truncated_flag;
      got.window = window;
      got.sequence_number = sequence_number;
      got.payload_length = payload_length;
      got.timestamp = timestamp;
      got.last = last;
      if (owed_results.size() == 0) begin
        if (n_bad < 10) $display("unexpected result: %s", fmt_result(got));
        n_bad++;
      end else begin
        want = owed_results.pop_front();
        if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
            got.status !== want.status || got.packet_type !== want.packet_type ||
            got.truncated_flag !== want.truncated_flag || got.window !== want.window ||
            got.sequence_number !== want.sequence_number ||
            got.payload_length !== want.payload_length ||
            got.timestamp !== want.timestamp || got.last !== want.last) begin
          if (n_bad < 10) begin
            $display("result mismatch at %0t", $realtime);
            $display("  expected %s", fmt_result(want));
            $display("  actual   %s", fmt_result(got));
          end
          n_bad++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99, 0) < recv_stall_pct);
  end

  // one transaction on the byte channel, with random gaps before it
  task automatic send_byte(input logic [7:0] b, input logic eof);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    data_byte <= b;
    end_of_frame <= eof;
    do @(posedge clk_i); while (in_stall);
    deframe_byte(b, eof);
    bytes_sent++;
  endtask

  // header, header crc, payload and payload crc into frame_buf
  task automatic build_frame(input logic [7:0] b0, input logic [15:0] len,
                             input bit bad_hdr_crc, input bit bad_pay_crc);
    logic [31:0] c;
    logic [7:0]  b;
    frame_buf.delete();
    frame_buf.push_back(b0);
    b = 8'($urandom);
    frame_buf.push_back(b);
    frame_buf.push_back(len[15:8]);
    frame_buf.push_back(len[7:0]);
    for (int i = 0; i < 4; i++) begin
      b = 8'($urandom);
      frame_buf.push_back(b);
    end
    c = CRC_INIT;
    for (int i = 0; i < HDR_LEN; i++) c = crc32_shift(c, frame_buf[i]);
    c = ~c;
    if (bad_hdr_crc) c = c ^ (32'd1 << $urandom_range(31, 0));
    for (int i = 3; i >= 0; i--) frame_buf.push_back(c[8*i +: 8]);
    if (len != 0 && len <= MAX_PAYLOAD) begin
      c = CRC_INIT;
      for (int i = 0; i < len; i++) begin
        b = 8'($urandom);
        frame_buf.push_back(b);
        c = crc32_shift(c, b);
      end
      c = ~c;
      if (bad_pay_crc) c = c ^ (32'd1 << $urandom_range(31, 0));
      for (int i = 3; i >= 0; i--) frame_buf.push_back(c[8*i +: 8]);
    end
  endtask

  // first n bytes of frame_buf, random filler past its end, eof on the last
  task automatic send_frame(input int unsigned n);
    logic [7:0] b;
    for (int unsigned i = 0; i < n; i++) begin
      if (i < frame_buf.size()) b = frame_buf[i];
      else b = 8'($urandom);
      send_byte(b, i == n - 1);
    end
  endtask

  task automatic test_bad_type();
    build_frame(8'h3F, 16'd0, 0, 0);
    send_frame(1);
  endtask

  task automatic test_length_limit();
    // over the limit wins over the truncated bit; huge lengths report saturated
    build_frame(8'hFF, 16'hFFFF, 0, 0);
    send_frame(4);
    build_frame(8'h40, 16'(MAX_PAYLOAD + 1), 0, 0);
    send_frame(4);
  endtask

  task automatic test_truncated_with_payload();
    build_frame(8'hA0, 16'd1, 0, 0);
    send_frame(4);
  endtask

  task automatic test_short_header();
    build_frame(8'h45, 16'd5, 0, 0);
    send_frame(3);
  endtask

  task automatic test_empty_payload();
    build_frame(8'h60, 16'd0, 0, 0);
    send_frame(frame_buf.size());
  endtask

  task automatic test_max_payload();
    build_frame(8'h5A, 16'(MAX_PAYLOAD), 0, 0);
    send_frame(frame_buf.size());
  endtask

  task automatic test_random_frames(input int unsigned budget);
    int unsigned pick;
    int unsigned total;
    int unsigned start;
    logic [1:0]  ptype;
    logic        trunc;
    logic [4:0]  win;
    logic [15:0] len;
    bit          bad_h;
    bit          bad_p;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      pick = $urandom_range(99, 0);
      ptype = 2'($urandom_range(3, 1));
      win = 5'($urandom);
      len = 16'($urandom_range(16, 0));
      trunc = 1'b0;
      if (len == 0) trunc = 1'($urandom_range(1, 0));
      bad_h = 0;
      bad_p = 0;
      if (pick >= 55 && pick < 63) begin
        bad_h = 1;
      end else if (pick >= 63 && pick < 71) begin
        bad_p = 1;
        if (len == 0) len = 1;
      end else if (pick >= 88 && pick < 94) begin
        case ($urandom_range(2, 0))
          0: ptype = 2'd0;
          1: len = 16'($urandom_range(16'hFFFF, MAX_PAYLOAD + 1));
          default: begin
            trunc = 1'b1;
            if (len == 0) len = 1;
          end
        endcase
      end
      build_frame({ptype, trunc, win}, len, bad_h, bad_p);
      total = frame_buf.size();
      if (pick >= 94) begin
        // noise
        frame_buf.delete();
        total = $urandom_range(20, 1);
      end else if (pick >= 71 && pick < 83) begin
        total = $urandom_range(total, 1);
      end else if (pick >= 83 && pick < 88) begin
        total += $urandom_range(3, 1);
      end
      send_frame(total);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    data_byte = 8'd0;
    end_of_frame = 1'b0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    n_bad = 0;
    bytes_sent = 0;
    clear_frame_state();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_bad_type();
    test_length_limit();
    test_truncated_with_payload();
    test_short_header();
    test_empty_payload();
    test_max_payload();

    test_random_frames(40);
    send_idle_pct = 54;
    recv_stall_pct = 0;
    test_random_frames(40);
    send_idle_pct = 0;
    recv_stall_pct = 54;
    test_random_frames(40);
    send_idle_pct = 27;
    recv_stall_pct = 27;
    test_random_frames(40);

    @(negedge clk_i);
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (n_bad == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
